[hdl/ialu_pkg.sv]
// Package for the RV32IM integer execute unit: operation codes, the control
// word that travels down the pipeline and divider sign flags. No dependencies.
`timescale 1ns / 1ps

package ialu_pkg;

    localparam int XLEN_DEF = 32;
    localparam int FUNC_W   = 5;
    localparam int REG_W    = 5;

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD    = 5'd0,
        FN_SUB    = 5'd1,
        FN_SLL    = 5'd2,
        FN_SLT    = 5'd3,
        FN_SLTU   = 5'd4,
        FN_XOR    = 5'd5,
        FN_SRL    = 5'd6,
        FN_SRA    = 5'd7,
        FN_OR     = 5'd8,
        FN_AND    = 5'd9,
        FN_MUL    = 5'd10,
        FN_MULH   = 5'd11,
        FN_MULHSU = 5'd12,
        FN_MULHU  = 5'd13,
        FN_DIV    = 5'd14,
        FN_DIVU   = 5'd15,
        FN_REM    = 5'd16,
        FN_REMU   = 5'd17,
        FN_LUI    = 5'd18,
        FN_AUIPC  = 5'd19
    } func_t;

    typedef struct packed {
        logic             valid;
        func_t            func;
        logic [REG_W-1:0] dest;
    } ctl_t;

    typedef struct packed {
        logic neg_q;
        logic neg_r;
    } div_flags_t;

endpackage

[hdl/ialu_front.sv]
// First pipeline stage: the ALU operations other than multiply and divide, and operand magnitudes
// for the multiplier and divider. Depends on ialu_pkg.
`timescale 1ns / 1ps

module ialu_front #(
    parameter int XLEN = ialu_pkg::XLEN_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  ialu_pkg::func_t            func,
    input  logic [XLEN-1:0]            op_a,
    input  logic [XLEN-1:0]            op_b,
    input  logic [XLEN-1:0]            pc_value,
    input  logic [ialu_pkg::REG_W-1:0] dest,
    output ialu_pkg::ctl_t             ctl_o,
    output logic [XLEN-1:0]            val_o,
    output logic [XLEN-1:0]            mag_a_o,
    output logic [XLEN-1:0]            mag_b_o,
    output logic                       neg_p_o,
    output ialu_pkg::div_flags_t       flags_o
);
    import ialu_pkg::*;

    localparam int SHW = $clog2(XLEN);

    ctl_t            ctl_reg;
    logic [XLEN-1:0] val_reg, val_next;
    logic [XLEN-1:0] mag_a_reg, mag_a_next;
    logic [XLEN-1:0] mag_b_reg, mag_b_next;
    logic            neg_p_reg, neg_p_next;
    div_flags_t      flags_reg, flags_next;
    logic [SHW-1:0]  sh;
    logic            a_signed, b_signed, sa, sb;

    always_comb begin
        sh = op_b[SHW-1:0];
        unique case (func)
            FN_ADD:   val_next = op_a + op_b;
            FN_SUB:   val_next = op_a - op_b;
            FN_SLL:   val_next = op_a << sh;
            FN_SLT:   val_next = {{(XLEN-1){1'b0}}, ($signed(op_a) < $signed(op_b))};
            FN_SLTU:  val_next = {{(XLEN-1){1'b0}}, (op_a < op_b)};
            FN_XOR:   val_next = op_a ^ op_b;
            FN_SRL:   val_next = op_a >> sh;
            FN_SRA:   val_next = XLEN'($signed(op_a) >>> sh);
            FN_OR:    val_next = op_a | op_b;
            FN_AND:   val_next = op_a & op_b;
            FN_LUI:   val_next = op_b;
            FN_AUIPC: val_next = pc_value + op_b;
            default:  val_next = '0;
        endcase
        a_signed = (func == FN_MULH) || (func == FN_MULHSU) || (func == FN_DIV)
                   || (func == FN_REM);
        b_signed = (func == FN_MULH) || (func == FN_DIV) || (func == FN_REM);
        sa = a_signed & op_a[XLEN-1];
        sb = b_signed & op_b[XLEN-1];
        mag_a_next = sa ? (~op_a + 1'b1) : op_a;
        mag_b_next = sb ? (~op_b + 1'b1) : op_b;
        neg_p_next = sa ^ sb;
        flags_next.neg_q = (sa ^ sb) & (op_b != '0);
        flags_next.neg_r = sa;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg.valid <= in_valid;
            ctl_reg.func  <= func;
            ctl_reg.dest  <= dest;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            val_reg   <= val_next;
            mag_a_reg <= mag_a_next;
            mag_b_reg <= mag_b_next;
            neg_p_reg <= neg_p_next;
            flags_reg <= flags_next;
        end
    end

    assign ctl_o   = ctl_reg;
    assign val_o   = val_reg;
    assign mag_a_o = mag_a_reg;
    assign mag_b_o = mag_b_reg;
    assign neg_p_o = neg_p_reg;
    assign flags_o = flags_reg;

endmodule

[hdl/ialu_mul.sv]
// Three-stage multiplier: half-width partial products, their sum, then the
// sign correction of the full product. Depends on ialu_pkg.
`timescale 1ns / 1ps

module ialu_mul #(
    parameter int XLEN = ialu_pkg::XLEN_DEF
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [XLEN-1:0]   mag_a,
    input  logic [XLEN-1:0]   mag_b,
    input  logic              neg,
    output logic [2*XLEN-1:0] prod
);
    import ialu_pkg::*;

    localparam int H = XLEN / 2;

    logic [XLEN-1:0]   ll_reg, lh_reg, hl_reg, hh_reg;
    logic              neg1_reg, neg2_reg;
    logic [2*XLEN-1:0] sum_reg, sum_next;
    logic [2*XLEN-1:0] prod_reg, prod_next;

    always_comb begin
        sum_next = {hh_reg, ll_reg}
                 + ({{XLEN{1'b0}}, lh_reg} << H)
                 + ({{XLEN{1'b0}}, hl_reg} << H);
        prod_next = neg2_reg ? (~sum_reg + 1'b1) : sum_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ll_reg   <= mag_a[H-1:0] * mag_b[H-1:0];
            lh_reg   <= mag_a[H-1:0] * mag_b[XLEN-1:H];
            hl_reg   <= mag_a[XLEN-1:H] * mag_b[H-1:0];
            hh_reg   <= mag_a[XLEN-1:H] * mag_b[XLEN-1:H];
            neg1_reg <= neg;
            sum_reg  <= sum_next;
            neg2_reg <= neg1_reg;
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

[hdl/ialu_div_stage.sv]
// One restoring division step: one quotient bit per stage, registered.
// Depends on ialu_pkg.
`timescale 1ns / 1ps

module ialu_div_stage #(
    parameter int XLEN = ialu_pkg::XLEN_DEF
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [XLEN-1:0]      quo_i,
    input  logic [XLEN-1:0]      rem_i,
    input  logic [XLEN-1:0]      dvs_i,
    input  ialu_pkg::div_flags_t flags_i,
    output logic [XLEN-1:0]      quo_o,
    output logic [XLEN-1:0]      rem_o,
    output logic [XLEN-1:0]      dvs_o,
    output ialu_pkg::div_flags_t flags_o
);
    import ialu_pkg::*;

    logic [XLEN:0]   trial, diff;
    logic            ge;
    logic [XLEN-1:0] quo_reg, quo_next, rem_reg, rem_next, dvs_reg;
    div_flags_t      flags_reg;

    always_comb begin
        trial    = {rem_i, quo_i[XLEN-1]};
        diff     = trial - {1'b0, dvs_i};
        ge       = !diff[XLEN];
        rem_next = ge ? diff[XLEN-1:0] : trial[XLEN-1:0];
        quo_next = {quo_i[XLEN-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quo_reg   <= quo_next;
            rem_reg   <= rem_next;
            dvs_reg   <= dvs_i;
            flags_reg <= flags_i;
        end
    end

    assign quo_o   = quo_reg;
    assign rem_o   = rem_reg;
    assign dvs_o   = dvs_reg;
    assign flags_o = flags_reg;

endmodule

[hdl/rv32im_integer_alu_unit.sv]
// Top level of the RV32IM integer execute unit: front stage, multiplier,
// divider stage chain and result pipeline. Depends on ialu_pkg and submodules.
`timescale 1ns / 1ps

// The unit accepts one request per cycle while s_tready is high. Every
// operation passes the front stage, the line stages beside the divider
// chain and the output register, so results return in order; the depth is
// set by the divider, one quotient bit per stage. A stall at the result
// side holds the whole pipeline and deasserts s_tready in the same cycle.
module rv32im_integer_alu_unit #(
    parameter int XLEN = ialu_pkg::XLEN_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // operand_a, operand_b, pc_value, dest_index from the lowest bit up
    input  logic [((3*XLEN+ialu_pkg::REG_W+7)/8)*8-1:0] s_tdata,
    // func
    input  logic [ialu_pkg::FUNC_W-1:0]  s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // result, dest_index_out from the lowest bit up
    output logic [((XLEN+ialu_pkg::REG_W+7)/8)*8-1:0] m_tdata
);
    import ialu_pkg::*;

    localparam int OUT_W = ((XLEN + REG_W + 7) / 8) * 8;
    localparam int MUL_JOIN = 4;

    logic            adv;
    ctl_t            line_ctl [0:XLEN];
    logic [XLEN-1:0] line_val [0:XLEN];
    logic [XLEN-1:0] mag_a, mag_b;
    logic            neg_p;
    logic [2*XLEN-1:0] prod;
    logic [XLEN-1:0] div_quo [0:XLEN];
    logic [XLEN-1:0] div_rem [0:XLEN];
    logic [XLEN-1:0] div_dvs [0:XLEN];
    div_flags_t      div_flg [0:XLEN];

    logic            m_valid_reg;
    logic [XLEN-1:0] m_result_reg, m_result_next;
    logic [REG_W-1:0] m_dest_reg;
    logic [XLEN-1:0] mul_sel;

    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;

    ialu_front #(.XLEN(XLEN)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_valid (s_tvalid),
        .func     (func_t'(s_tuser)),
        .op_a     (s_tdata[XLEN-1:0]),
        .op_b     (s_tdata[2*XLEN-1:XLEN]),
        .pc_value (s_tdata[3*XLEN-1:2*XLEN]),
        .dest     (s_tdata[3*XLEN+REG_W-1:3*XLEN]),
        .ctl_o    (line_ctl[0]),
        .val_o    (line_val[0]),
        .mag_a_o  (mag_a),
        .mag_b_o  (mag_b),
        .neg_p_o  (neg_p),
        .flags_o  (div_flg[0])
    );

    ialu_mul #(.XLEN(XLEN)) u_mul (
        .aclk  (aclk),
        .en    (adv),
        .mag_a (mag_a),
        .mag_b (mag_b),
        .neg   (neg_p),
        .prod  (prod)
    );

    assign div_quo[0] = mag_a;
    assign div_rem[0] = '0;
    assign div_dvs[0] = mag_b;

    for (genvar k = 0; k < XLEN; k++) begin : g_div
        ialu_div_stage #(.XLEN(XLEN)) u_stage (
            .aclk    (aclk),
            .en      (adv),
            .quo_i   (div_quo[k]),
            .rem_i   (div_rem[k]),
            .dvs_i   (div_dvs[k]),
            .flags_i (div_flg[k]),
            .quo_o   (div_quo[k+1]),
            .rem_o   (div_rem[k+1]),
            .dvs_o   (div_dvs[k+1]),
            .flags_o (div_flg[k+1])
        );
    end

    always_comb begin
        unique case (line_ctl[MUL_JOIN-1].func)
            FN_MUL:                        mul_sel = prod[XLEN-1:0];
            FN_MULH, FN_MULHSU, FN_MULHU:  mul_sel = prod[2*XLEN-1:XLEN];
            default:                       mul_sel = line_val[MUL_JOIN-1];
        endcase
    end

    for (genvar i = 1; i <= XLEN; i++) begin : g_line
        ctl_t            ctl_reg;
        logic [XLEN-1:0] val_reg;
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_reg <= '0;
            end else if (adv) begin
                ctl_reg <= line_ctl[i-1];
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                val_reg <= (i == MUL_JOIN) ? mul_sel : line_val[i-1];
            end
        end
        assign line_ctl[i] = ctl_reg;
        assign line_val[i] = val_reg;
    end

    always_comb begin
        unique case (line_ctl[XLEN].func)
            FN_DIV, FN_DIVU: m_result_next = div_flg[XLEN].neg_q
                                 ? (~div_quo[XLEN] + 1'b1) : div_quo[XLEN];
            FN_REM, FN_REMU: m_result_next = div_flg[XLEN].neg_r
                                 ? (~div_rem[XLEN] + 1'b1) : div_rem[XLEN];
            default:         m_result_next = line_val[XLEN];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= line_ctl[XLEN].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_result_reg <= m_result_next;
            m_dest_reg   <= line_ctl[XLEN].dest;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_W-XLEN-REG_W){1'b0}}, m_dest_reg, m_result_reg};

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while the result side is stalled");

    a_empty_output_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with an empty output register");

    a_request_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> line_ctl[0].valid)
        else $error("accepted request missing from the first stage");

    a_divu_by_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (line_ctl[XLEN].valid && line_ctl[XLEN].func == FN_DIVU && div_dvs[XLEN] == '0)
        |-> (div_quo[XLEN] == {XLEN{1'b1}}))
        else $error("unsigned divide by zero did not give all ones");

endmodule
